// ===== hw/rtl/dlcd_pkg.sv =====
// Shared types, constants and the digit segment table for the decimal LCD segment encoder.
// Used by dlcd_stage and decimal_lcd_segment_encoder_core; no dependencies of its own.
package dlcd_pkg;

	localparam int VALUE_W     = 31;
	localparam int ROW_W       = 24;
	localparam int NIB_W       = 4;
	localparam int QUOT_W      = 28;
	localparam int PROD_W      = 63;
	localparam int RECIP_SHIFT = 35;

	// Reciprocal of ten scaled by 2^35; exact quotient for every 32-bit dividend.
	localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;

	typedef struct packed {
		logic [ROW_W-1:0] feet;
		logic [ROW_W-1:0] legs;
		logic [ROW_W-1:0] chest;
		logic [ROW_W-1:0] head;
	} rows_t;

	typedef struct packed {
		logic [VALUE_W-1:0] rest;
		rows_t              rows;
	} stage_t;

	typedef struct packed {
		logic [NIB_W-1:0] feet;
		logic [NIB_W-1:0] legs;
		logic [NIB_W-1:0] chest;
		logic [NIB_W-1:0] head;
	} seg_t;

	// Nibble patterns of one digit in the four rows.
	function automatic seg_t seg_lookup(input logic [NIB_W-1:0] digit);
		seg_t s;
		case (digit)
			4'd0: s = '{feet: 4'h1, legs: 4'h5, chest: 4'h5, head: 4'h1};
			4'd1: s = '{feet: 4'h0, legs: 4'h1, chest: 4'h1, head: 4'h0};
			4'd2: s = '{feet: 4'h1, legs: 4'hE, chest: 4'h1, head: 4'h1};
			4'd3: s = '{feet: 4'h1, legs: 4'hB, chest: 4'h1, head: 4'h1};
			4'd4: s = '{feet: 4'h0, legs: 4'hB, chest: 4'h5, head: 4'h0};
			4'd5: s = '{feet: 4'h1, legs: 4'hB, chest: 4'h4, head: 4'h1};
			4'd6: s = '{feet: 4'h1, legs: 4'hF, chest: 4'h4, head: 4'h1};
			4'd7: s = '{feet: 4'h0, legs: 4'h1, chest: 4'h1, head: 4'h1};
			4'd8: s = '{feet: 4'h1, legs: 4'hF, chest: 4'h5, head: 4'h1};
			4'd9: s = '{feet: 4'h0, legs: 4'hB, chest: 4'h5, head: 4'h1};
			default: s = '0;
		endcase
		return s;
	endfunction

endpackage

// ===== hw/rtl/dlcd_stage.sv =====
// One pipeline stage of the decimal LCD segment encoder: peels off one decimal digit.
// Depends on dlcd_pkg for the stage payload type and the segment table.
module dlcd_stage
	import dlcd_pkg::*;
#(
	parameter int POS   = 5,
	parameter bit UNITS = 1'b0
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  stage_t in_data,
	output logic   out_valid,
	input  logic   out_ready,
	output stage_t out_data
);

	localparam int SHIFT = NIB_W * POS;

	logic                valid_q;
	stage_t              data_q;
	stage_t              nxt;
	logic [PROD_W-1:0]   prod;
	logic [QUOT_W-1:0]   quot;
	logic [NIB_W-1:0]    q_ten_lo;
	logic [NIB_W-1:0]    digit;
	logic                show;
	seg_t                seg;

	always_comb begin
		prod     = PROD_W'(in_data.rest) * PROD_W'(RECIP_TEN);
		quot     = prod[PROD_W-1:RECIP_SHIFT];
		// The remainder is below ten, so four low bits of rest - 10*quot suffice.
		q_ten_lo = {quot[0], 3'b000} + {quot[2:0], 1'b0};
		digit    = in_data.rest[NIB_W-1:0] - q_ten_lo;
		show     = UNITS || (in_data.rest != '0);
		seg      = seg_lookup(digit);

		nxt.rest = VALUE_W'(quot);
		nxt.rows = in_data.rows;
		if (show) begin
			nxt.rows.head  = in_data.rows.head  | (ROW_W'(seg.head)  << SHIFT);
			nxt.rows.chest = in_data.rows.chest | (ROW_W'(seg.chest) << SHIFT);
			nxt.rows.legs  = in_data.rows.legs  | (ROW_W'(seg.legs)  << SHIFT);
			nxt.rows.feet  = in_data.rows.feet  | (ROW_W'(seg.feet)  << SHIFT);
		end
	end

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= nxt;
		end
	end

endmodule

// ===== hw/rtl/decimal_lcd_segment_encoder_core.sv =====
// Top level of the decimal LCD segment encoder: a chain of digit stages with stream ports.
// Depends on dlcd_pkg and dlcd_stage.
//
// Usage:
// A request on the slave side (s_tvalid/s_tready/s_tdata) carries one non-negative number
// in s_tdata[30:0]; bit 31 is padding and is ignored. For every request the block returns
// one request on the master side (m_tvalid/m_tready/m_tdata) with the four row words of a
// DIGIT_COUNT-digit multiplexed LCD image: head, chest, legs and feet rows, 24 bits each.
// Digit position p occupies nibble p of every row word (column p/2, low nibble for even p),
// and the units digit sits at position DIGIT_COUNT-1. Leading positions are blank, zero
// shows a single '0', and digits above the lowest DIGIT_COUNT are dropped.
//
// Each stage holds one number, divides it by ten with a reciprocal multiplier and ORs the
// segment nibbles of the remainder into the rows it carries, so one request is taken
// every cycle as long as the receiver does not stall. The last stage is the output register.
//
// Reset clears all stage valid bits; the block takes requests from the first cycle after
// reset. When the receiver stalls, the stages fill up one by one and s_tready falls only
// once every stage holds a request; nothing is lost or repeated.
module decimal_lcd_segment_encoder_core
	import dlcd_pkg::*;
#(
	parameter int DIGIT_COUNT = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [30:0] value, [31] zero padding
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata    // [23:0] head_row, [47:24] chest_row,
	                               // [71:48] legs_row, [95:72] feet_row
);

	localparam int                 USED_W   = NIB_W * DIGIT_COUNT;
	localparam int                 UNIT_LSB = NIB_W * (DIGIT_COUNT - 1);
	localparam logic [VALUE_W-1:0] REST_MAX = VALUE_W'(32'h7FFF_FFFF / (10 ** DIGIT_COUNT));

	// Link k feeds stage k; link DIGIT_COUNT is the output of the last stage.
	logic   [DIGIT_COUNT:0] valid;
	logic   [DIGIT_COUNT:0] ready;
	stage_t                 data [DIGIT_COUNT+1];

	assign valid[0]     = s_tvalid;
	assign s_tready     = ready[0];
	assign data[0].rest = s_tdata[VALUE_W-1:0];
	assign data[0].rows = '0;

	// Stage k handles the digit k places above the units.
	for (genvar k = 0; k < DIGIT_COUNT; k++) begin : g_stage
		dlcd_stage #(
			.POS   (DIGIT_COUNT - 1 - k),
			.UNITS (k == 0)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (valid[k]),
			.in_ready  (ready[k]),
			.in_data   (data[k]),
			.out_valid (valid[k+1]),
			.out_ready (ready[k+1]),
			.out_data  (data[k+1])
		);
	end

	assign m_tvalid           = valid[DIGIT_COUNT];
	assign ready[DIGIT_COUNT] = m_tready;
	assign m_tdata            = data[DIGIT_COUNT].rows;

	// After DIGIT_COUNT divisions by ten, what is left of a 31-bit number is bounded.
	a_rest_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (data[DIGIT_COUNT].rest <= REST_MAX))
		else $error("leftover quotient exceeds bound");

	// The units digit is always shown, and every digit lights its chest row.
	a_units_shown: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (data[DIGIT_COUNT].rows.chest[UNIT_LSB +: NIB_W] != '0))
		else $error("units digit blank");

	// Nibbles that belong to no digit position stay clear.
	a_unused_clear: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (((data[DIGIT_COUNT].rows.head  >> USED_W) == '0)
			&& ((data[DIGIT_COUNT].rows.chest >> USED_W) == '0)
			&& ((data[DIGIT_COUNT].rows.legs  >> USED_W) == '0)
			&& ((data[DIGIT_COUNT].rows.feet  >> USED_W) == '0)))
		else $error("unused nibble set");

	// Input backpressure only when every stage is full and the output is stalled.
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready
			&& (valid[DIGIT_COUNT:1] == {DIGIT_COUNT{1'b1}})))
		else $error("input stalled with room in the pipeline");

endmodule
